// ===== design/assert_macros.svh =====
// Assertion macros for the deque RTL, used by dq_ctrl.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked property, switched off while reset is high.
`define DQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("deque assertion failed");
// Clocked property checked in every cycle, reset included.
`define DQ_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("deque assertion failed");
`else
`define DQ_ASSERT(lbl, clk, rst, prop)
`define DQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== design/dq_pkg.sv =====
// Shared types and constants for the double-ended queue.
// No dependencies; compiled before every other file.
`default_nettype none

package dq_pkg;

   localparam int DEPTH_DEF      = 32;
   localparam int VALUE_W        = 32;
   localparam int OP_W           = 3;
   localparam int STATUS_W       = 2;
   localparam int OCC_W_DEF      = $clog2(DEPTH_DEF + 1);
   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_CNT_W      = $clog2(RSP_FIFO_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_LIST_FWD   = 3'd4,
      OP_LIST_BWD   = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Control that travels with a result through the read stage.
   typedef struct packed {
      logic       use_mem;
      status_type status;
      logic       last;
   } rsp_ctl_type;

endpackage

`default_nettype wire

// ===== design/dq_if.sv =====
// Valid/ready channel interfaces for deque requests and responses.
// Depends on dq_pkg.
`default_nettype none

interface dq_req_if;
   import dq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            operation;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, operation, value, input ready);
   modport sink   (input valid, operation, value, output ready);
endinterface

interface dq_rsp_if #(
   parameter int OCC_W = dq_pkg::OCC_W_DEF
);
   import dq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic signed [VALUE_W-1:0]  value_res;
   logic [OCC_W-1:0]           occupancy;
   logic                       last;

   modport source (output valid, status, value_res, occupancy, last, input ready);
   modport sink   (input valid, status, value_res, occupancy, last, output ready);
endinterface

`default_nettype wire

// ===== design/dq_store.sv =====
// Element store: synchronous RAM with a write port and a separate read port,
// read data registered. Depends on dq_pkg.
`default_nettype none

module dq_store #(
   parameter int   DEPTH = dq_pkg::DEPTH_DEF,
   localparam int  IDX_W = $clog2(DEPTH)
) (
   input  wire logic                         clock,
   input  wire logic                         we,
   input  wire logic [IDX_W-1:0]             waddr,
   input  wire logic [dq_pkg::VALUE_W-1:0]   wdata,
   input  wire logic                         re,
   input  wire logic [IDX_W-1:0]             raddr,
   output      logic [dq_pkg::VALUE_W-1:0]   rdata
);
   import dq_pkg::*;

   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [VALUE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/dq_rsp_fifo.sv =====
// Small response queue between the read stage and the response channel.
// Depends on dq_pkg.
`default_nettype none

module dq_rsp_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire logic [WIDTH-1:0]              push_data,
   output      logic                          out_valid,
   input  wire logic                          out_ready,
   output      logic [WIDTH-1:0]              out_data,
   output      logic [dq_pkg::RSP_CNT_W-1:0]  count
);
   import dq_pkg::*;

   localparam int PTR_W = $clog2(RSP_FIFO_DEPTH);

   logic [WIDTH-1:0]     entry_ff [RSP_FIFO_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/dq_ctrl.sv =====
// Deque sequencer: front index, fill count, listing walk and read stage.
// Drives the element store. Depends on dq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dq_ctrl #(
   parameter int   DEPTH = dq_pkg::DEPTH_DEF,
   localparam int  IDX_W = $clog2(DEPTH),
   localparam int  CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [dq_pkg::OP_W-1:0]       req_op,
   input  wire logic [dq_pkg::VALUE_W-1:0]    req_value,
   input  wire logic [dq_pkg::RSP_CNT_W-1:0]  fifo_count,
   output      logic                          mem_we,
   output      logic [IDX_W-1:0]              mem_waddr,
   output      logic [dq_pkg::VALUE_W-1:0]    mem_wdata,
   output      logic                          mem_re,
   output      logic [IDX_W-1:0]              mem_raddr,
   output      logic                          s1_valid,
   output      dq_pkg::rsp_ctl_type           s1_ctl,
   output      logic [CNT_W-1:0]              s1_occ
);
   import dq_pkg::*;

   localparam int SUM_W = CNT_W + 1;
   localparam int SPC_W = RSP_CNT_W + 1;

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             list_ff, list_in;
   logic             list_bwd_ff, list_bwd_in;
   logic [CNT_W-1:0] list_pos_ff, list_pos_in;
   logic             s1_valid_ff, s1_valid_in;
   rsp_ctl_type      s1_ctl_ff, s1_ctl_in;
   logic [CNT_W-1:0] s1_occ_ff, s1_occ_in;

   logic             space;
   logic             accept;
   logic             list_step;
   logic             full;
   logic             empty;
   logic [CNT_W-1:0] last_pos;
   logic [IDX_W-1:0] front_dec;
   logic [IDX_W-1:0] front_inc;
   op_type           opc;

   // Position of the element at a given offset from the front, modulo DEPTH.
   function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                             input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // Room in the response queue counting the result in the read stage.
   assign space     = (SPC_W'(fifo_count) + SPC_W'(s1_valid_ff)) < SPC_W'(RSP_FIFO_DEPTH);
   assign req_ready = !list_ff && space;
   assign accept    = req_valid && req_ready;
   assign list_step = list_ff && space;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign last_pos  = count_ff - 1'b1;
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign opc       = op_type'(req_op);
   assign mem_wdata = req_value;

   always_comb begin
      front_in    = front_ff;
      count_in    = count_ff;
      list_in     = list_ff;
      list_bwd_in = list_bwd_ff;
      list_pos_in = list_pos_ff;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_re      = 1'b0;
      mem_raddr   = '0;
      s1_valid_in = 1'b0;
      s1_ctl_in   = '{use_mem: 1'b0, status: ST_OK, last: 1'b1};
      s1_occ_in   = count_ff;

      if (list_step) begin
         mem_re            = 1'b1;
         mem_raddr         = list_bwd_ff ? slot(front_ff, last_pos - list_pos_ff)
                                         : slot(front_ff, list_pos_ff);
         s1_valid_in       = 1'b1;
         s1_ctl_in.use_mem = 1'b1;
         s1_ctl_in.last    = (list_pos_ff == last_pos);
         list_pos_in       = list_pos_ff + 1'b1;
         if (list_pos_ff == last_pos) begin
            list_in = 1'b0;
         end
      end else if (accept) begin
         s1_valid_in = 1'b1;
         unique case (opc) inside
            OP_PUSH_FRONT: begin
               if (full) begin
                  s1_ctl_in.status = ST_FULL;
               end else begin
                  front_in  = front_dec;
                  mem_we    = 1'b1;
                  mem_waddr = front_dec;
                  count_in  = count_ff + 1'b1;
                  s1_occ_in = count_ff + 1'b1;
               end
            end
            OP_PUSH_BACK: begin
               if (full) begin
                  s1_ctl_in.status = ST_FULL;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = slot(front_ff, count_ff);
                  count_in  = count_ff + 1'b1;
                  s1_occ_in = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  s1_ctl_in.status = ST_EMPTY;
               end else begin
                  mem_re            = 1'b1;
                  mem_raddr         = front_ff;
                  front_in          = front_inc;
                  count_in          = last_pos;
                  s1_occ_in         = last_pos;
                  s1_ctl_in.use_mem = 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  s1_ctl_in.status = ST_EMPTY;
               end else begin
                  mem_re            = 1'b1;
                  mem_raddr         = slot(front_ff, last_pos);
                  count_in          = last_pos;
                  s1_occ_in         = last_pos;
                  s1_ctl_in.use_mem = 1'b1;
               end
            end
            OP_LIST_FWD, OP_LIST_BWD: begin
               if (empty) begin
                  s1_ctl_in.status = ST_EMPTY;
               end else begin
                  // results come from the listing walk that list_ff starts
                  s1_valid_in = 1'b0;
                  list_in     = 1'b1;
                  list_bwd_in = (opc == OP_LIST_BWD);
                  list_pos_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      list_bwd_ff <= list_bwd_in;
      list_pos_ff <= list_pos_in;
      s1_ctl_ff   <= s1_ctl_in;
      s1_occ_ff   <= s1_occ_in;
      if (reset) begin
         front_ff    <= '0;
         count_ff    <= '0;
         list_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         front_ff    <= front_in;
         count_ff    <= count_in;
         list_ff     <= list_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_ctl   = s1_ctl_ff;
   assign s1_occ   = s1_occ_ff;

   `DQ_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `DQ_ASSERT(a_list_freezes_state, clock, reset, list_ff |=> $stable(count_ff) && $stable(front_ff))
   `DQ_ASSERT(a_single_store_access, clock, reset, !(mem_we && mem_re))
   `DQ_ASSERT(a_write_grows_count, clock, reset, mem_we |=> count_ff == $past(count_ff) + 1'b1)

endmodule

`default_nettype wire

// ===== design/double_ended_queue.sv =====
// Double-ended queue: push and pop complete one per cycle while the response queue has
// room; a result passes through the store read stage, then the response queue.
// A listing holds off requests from its transfer until its last element is read, while
// one element a cycle, when the response queue has room, streams out of the store read port.
// Reset clears front index, fill count and response queue; store contents stay
// undefined until written, with no clearing pass.
`default_nettype none

module double_ended_queue #(
   parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dq_req_if.sink     req_chan,
   dq_rsp_if.source   rsp_chan
);
   import dq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int RSP_W = STATUS_W + VALUE_W + OCC_W + 1;

   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [VALUE_W-1:0]   mem_wdata;
   logic                 mem_re;
   logic [IDX_W-1:0]     mem_raddr;
   logic [VALUE_W-1:0]   mem_rdata;
   logic                 s1_valid;
   rsp_ctl_type          s1_ctl;
   logic [OCC_W-1:0]     s1_occ;
   logic [RSP_CNT_W-1:0] fifo_count;
   logic [RSP_W-1:0]     s1_data;
   logic [RSP_W-1:0]     rsp_data;

   dq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_op     (req_chan.operation),
      .req_value  (req_chan.value),
      .fifo_count (fifo_count),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .s1_valid   (s1_valid),
      .s1_ctl     (s1_ctl),
      .s1_occ     (s1_occ)
   );

   dq_store #(.DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Value is zero unless the result carries a stored element.
   assign s1_data = {s1_ctl.status,
                     (s1_ctl.use_mem ? mem_rdata : {VALUE_W{1'b0}}),
                     s1_occ,
                     s1_ctl.last};

   dq_rsp_fifo #(.WIDTH(RSP_W)) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid),
      .push_data (s1_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data),
      .count     (fifo_count)
   );

   assign rsp_chan.status    = rsp_data[RSP_W-1 -: STATUS_W];
   assign rsp_chan.value_res = rsp_data[OCC_W+1 +: VALUE_W];
   assign rsp_chan.occupancy = rsp_data[1 +: OCC_W];
   assign rsp_chan.last      = rsp_data[0];

endmodule

`default_nettype wire
